FILE: rtl/kdpc_pkg.sv
// ----------------------------------------------------------------------------
// kdpc_pkg
// Shared types and constants of the key debounce and press classifier.
// ----------------------------------------------------------------------------
package kdpc_pkg;

	// Number of key slots carried on the ports
	localparam int KEY_SLOTS = 6;
	// Default number of keys in use
	localparam int NUM_KEYS_DEF = 6;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [KEY_SLOTS-1:0]  key_mask_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Configuration register indexes
	localparam cfg_idx_t REG_ACTIVE_LEVELS = 2'd0;
	localparam cfg_idx_t REG_TIME_STEP     = 2'd1;
	localparam cfg_idx_t REG_DEBOUNCE      = 2'd2;
	localparam cfg_idx_t REG_LONG_PRESS    = 2'd3;

	// Register reset values
	localparam key_mask_t   ACTIVE_LEVELS_RST = '0;
	localparam logic [7:0]  TIME_STEP_RST     = 8'd10;
	localparam logic [15:0] DEBOUNCE_RST      = 16'd20;
	localparam logic [15:0] LONG_PRESS_RST    = 16'd1000;

	// Per-key event code
	typedef enum logic [2:0] {
		EVT_NONE  = 3'd0,
		EVT_DOWN  = 3'd1,
		EVT_UP    = 3'd2,
		EVT_SHORT = 3'd3,
		EVT_LONG  = 3'd4
	} event_t;

	// Timing settings shared by every lane
	typedef struct packed {
		logic [7:0]  time_step;
		logic [15:0] debounce_period;
		logic [15:0] long_press_period;
	} timing_t;

endpackage

FILE: rtl/kdpc_if.sv
// ----------------------------------------------------------------------------
// kdpc_if
// Valid/ready channels: raw key tick in, classified result out.
// ----------------------------------------------------------------------------
interface kdpc_tick_if;
	logic                 valid;
	logic                 ready;
	kdpc_pkg::key_mask_t  pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

interface kdpc_result_if;
	logic                 valid;
	logic                 ready;
	kdpc_pkg::key_mask_t  pressed_mask;
	kdpc_pkg::event_t     event_key0;
	kdpc_pkg::event_t     event_key1;
	kdpc_pkg::event_t     event_key2;
	kdpc_pkg::event_t     event_key3;
	kdpc_pkg::event_t     event_key4;
	kdpc_pkg::event_t     event_key5;

	modport source (output valid, output pressed_mask, output event_key0, output event_key1,
		output event_key2, output event_key3, output event_key4, output event_key5,
		input ready);
	modport sink   (input valid, input pressed_mask, input event_key0, input event_key1,
		input event_key2, input event_key3, input event_key4, input event_key5,
		output ready);
endinterface

FILE: rtl/kdpc_lane.sv
// ----------------------------------------------------------------------------
// kdpc_lane
// One key: debounce counter, stable state and press-time classifier.
// ----------------------------------------------------------------------------
module kdpc_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              pin_bit,
	input  logic              active_bit,
	input  kdpc_pkg::timing_t timing,
	output logic              stable,
	output kdpc_pkg::event_t  evt
);
	import kdpc_pkg::*;

	logic        raw_q;
	logic        stable_q;   // also the previous stable level of the next tick
	logic [15:0] settle_q;
	logic [15:0] hold_q;

	logic        now;
	logic        raw_d;
	logic        stable_d;
	logic [15:0] settle_d;
	logic [15:0] hold_d;
	logic [16:0] settle_sum;
	logic [16:0] hold_sum;
	logic [15:0] hold_sat;

	assign now        = (pin_bit == active_bit);
	assign settle_sum = {1'b0, settle_q} + {9'b0, timing.time_step};
	assign hold_sum   = {1'b0, hold_q} + {9'b0, timing.time_step};
	assign hold_sat   = hold_sum[16] ? 16'hFFFF : hold_sum[15:0];

	// Debounce: restart on a change, otherwise count up to the period
	always_comb begin
		raw_d    = raw_q;
		stable_d = stable_q;
		settle_d = settle_q;
		if (now != raw_q) begin
			raw_d    = now;
			settle_d = '0;
		end else if (settle_sum >= {1'b0, timing.debounce_period}) begin
			stable_d = raw_q;
			settle_d = timing.debounce_period;
		end else begin
			settle_d = settle_sum[15:0];
		end
	end

	// Classify edges of the stable level and track hold time
	always_comb begin
		evt    = EVT_NONE;
		hold_d = hold_q;
		if (stable_d && !stable_q) begin
			evt    = EVT_DOWN;
			hold_d = '0;
		end else if (!stable_d && stable_q) begin
			if (hold_q >= timing.debounce_period && hold_q < timing.long_press_period)
				evt = EVT_SHORT;
			else
				evt = EVT_UP;
		end else if (stable_d && stable_q) begin
			hold_d = hold_sat;
			if (hold_sat == timing.long_press_period && hold_q != timing.long_press_period)
				evt = EVT_LONG;
		end
	end

	assign stable = stable_d;

	// Advance key state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b0;
			stable_q <= 1'b0;
			settle_q <= '0;
			hold_q   <= '0;
		end else if (en) begin
			raw_q    <= raw_d;
			stable_q <= stable_d;
			settle_q <= settle_d;
			hold_q   <= hold_d;
		end
	end

endmodule

FILE: rtl/kdpc_merge.sv
// ----------------------------------------------------------------------------
// kdpc_merge
// Collect the lane results into one result transaction and hold it until taken.
// ----------------------------------------------------------------------------
module kdpc_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  kdpc_pkg::key_mask_t lane_stable,
	input  kdpc_pkg::event_t    lane_evt [kdpc_pkg::KEY_SLOTS],
	output logic                space,
	kdpc_result_if.source       result
);
	import kdpc_pkg::*;

	logic      valid_q;
	key_mask_t mask_q;
	event_t    evt_q [KEY_SLOTS];

	assign space = !valid_q || result.ready;

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the merged payload
	always_ff @(posedge clk) begin
		if (load) begin
			mask_q <= lane_stable;
			evt_q  <= lane_evt;
		end
	end

	assign result.valid        = valid_q;
	assign result.pressed_mask = mask_q;
	assign result.event_key0   = evt_q[0];
	assign result.event_key1   = evt_q[1];
	assign result.event_key2   = evt_q[2];
	assign result.event_key3   = evt_q[3];
	assign result.event_key4   = evt_q[4];
	assign result.event_key5   = evt_q[5];

endmodule

FILE: rtl/key_debounce_press_classifier_core.sv
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_core
// Debounces up to six keys and reports down, up, short and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transaction per sampling tick, carrying the raw pin levels.
//   result : one transaction per tick: debounced pressed mask and one event
//            code per key (none, down, up, short, long).
//   cfg_*  : register write port (active levels, time step, debounce period,
//            long press period); write only while no tick is in flight.
//   Each key has its own lane; all lanes update in parallel in the cycle a
//   tick is accepted, and the result is registered, so result valid rises
//   in the cycle after tick acceptance. Throughput is one tick per cycle
//   while results are taken, set by the single output register, which loads
//   while its old result is taken in the same cycle.
//   If the receiver stalls, the output register holds its result and tick
//   ready drops until it is taken; no result is lost or repeated.
//   Reset clears all key state and the output valid flag, and loads the
//   register defaults (active levels 0, step 10, debounce 20, long press 1000).
//   Keys at or above NUM_KEYS read as released with no events.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_core #(
	parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	kdpc_tick_if.sink           tick,
	kdpc_result_if.source       result,
	input  logic                cfg_we,
	input  kdpc_pkg::cfg_idx_t  cfg_idx,
	input  kdpc_pkg::cfg_data_t cfg_wdata
);
	import kdpc_pkg::*;

	key_mask_t active_q;
	timing_t   timing_q;

	logic      take;
	logic      space;
	key_mask_t lane_stable;
	event_t    lane_evt [KEY_SLOTS];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q                   <= ACTIVE_LEVELS_RST;
			timing_q.time_step         <= TIME_STEP_RST;
			timing_q.debounce_period   <= DEBOUNCE_RST;
			timing_q.long_press_period <= LONG_PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACTIVE_LEVELS: active_q <= cfg_wdata[KEY_SLOTS-1:0];
				REG_TIME_STEP:     timing_q.time_step <= cfg_wdata[7:0];
				REG_DEBOUNCE:      timing_q.debounce_period <= cfg_wdata;
				REG_LONG_PRESS:    timing_q.long_press_period <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign tick.ready = space;
	assign take       = tick.valid && space;

	// One lane per key in use; unused slots stay released
	for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_lane
		if (k < NUM_KEYS) begin : g_on
			kdpc_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (take),
				.pin_bit    (tick.pin_levels[k]),
				.active_bit (active_q[k]),
				.timing     (timing_q),
				.stable     (lane_stable[k]),
				.evt        (lane_evt[k])
			);
		end else begin : g_off
			assign lane_stable[k] = 1'b0;
			assign lane_evt[k]    = EVT_NONE;
		end
	end

	kdpc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take),
		.lane_stable (lane_stable),
		.lane_evt    (lane_evt),
		.space       (space),
		.result      (result)
	);

endmodule

FILE: verif/tb_key_debounce_press_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_key_debounce_press_classifier_core
// Self-checking bench for the six-key debounce and press classifier. A local
// per-key predictor follows every accepted tick and produces the expected
// pressed mask and events. Each result transaction is compared with the
// oldest expectation. Stimulus is a short directed sequence followed by
// random key activity (held levels with contact bounce) under several timing
// settings and flow-control patterns.
// ----------------------------------------------------------------------------
module tb_key_debounce_press_classifier_core;
	import kdpc_pkg::*;

	localparam int LANES        = NUM_KEYS_DEF;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_OFF_LEN = 300;

	typedef struct {
		key_mask_t mask;
		event_t    evt[KEY_SLOTS];
	} key_result_t;

	// Per-key debounce and press classifier, plus the queue of results due
	class key_event_scoreboard;
		key_mask_t   active_lv;
		logic [7:0]  step;
		logic [15:0] debounce;
		logic [15:0] long_press;
		bit          raw_seen[KEY_SLOTS];
		bit          stable[KEY_SLOTS];
		bit          prev_stable[KEY_SLOTS];
		logic [15:0] settle[KEY_SLOTS];
		logic [15:0] hold[KEY_SLOTS];
		key_result_t results_due[$];
		int          errors;

		function new();
			active_lv  = ACTIVE_LEVELS_RST;
			step       = TIME_STEP_RST;
			debounce   = DEBOUNCE_RST;
			long_press = LONG_PRESS_RST;
			errors     = 0;
			for (int k = 0; k < KEY_SLOTS; k++) begin
				raw_seen[k]    = 1'b0;
				stable[k]      = 1'b0;
				prev_stable[k] = 1'b0;
				settle[k]      = '0;
				hold[k]        = '0;
			end
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				REG_ACTIVE_LEVELS: active_lv  = data[KEY_SLOTS-1:0];
				REG_TIME_STEP:     step       = data[7:0];
				REG_DEBOUNCE:      debounce   = data;
				REG_LONG_PRESS:    long_press = data;
				default: ;
			endcase
		endfunction

		// Advance every key by one tick and queue the result it gives
		function void note_tick(key_mask_t pins);
			key_result_t r;
			int          sum;
			bit          now;
			logic [15:0] old_hold;
			r.mask = '0;
			for (int k = 0; k < KEY_SLOTS; k++) begin
				r.evt[k] = EVT_NONE;
				if (k < LANES) begin
					now = (pins[k] == active_lv[k]);
					// debounce: a change restarts the settle count
					if (now != raw_seen[k]) begin
						raw_seen[k] = now;
						settle[k]   = '0;
					end else begin
						sum = int'(settle[k]) + int'(step);
						if (sum >= int'(debounce)) begin
							stable[k] = raw_seen[k];
							settle[k] = debounce;
						end else begin
							settle[k] = sum[15:0];
						end
					end
					// classify edges of the stable level
					if (stable[k] && !prev_stable[k]) begin
						r.evt[k] = EVT_DOWN;
						hold[k]  = '0;
					end else if (!stable[k] && prev_stable[k]) begin
						if (hold[k] >= debounce && hold[k] < long_press)
							r.evt[k] = EVT_SHORT;
						else
							r.evt[k] = EVT_UP;
					end else if (stable[k] && prev_stable[k]) begin
						old_hold = hold[k];
						sum = int'(old_hold) + int'(step);
						if (sum > 65535)
							sum = 65535;
						hold[k] = sum[15:0];
						if (hold[k] == long_press && old_hold != long_press)
							r.evt[k] = EVT_LONG;
					end
					prev_stable[k] = stable[k];
					r.mask[k]      = stable[k];
				end
			end
			results_due.push_back(r);
		endfunction

		function void check_result(key_result_t got);
			key_result_t want;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: result expected none actual mask %h", $time, got.mask);
				return;
			end
			want = results_due.pop_front();
			if (got.mask !== want.mask) begin
				errors++;
				$display("%0t: pressed_mask expected %h actual %h",
					$time, want.mask, got.mask);
			end
			for (int k = 0; k < KEY_SLOTS; k++) begin
				if (got.evt[k] !== want.evt[k]) begin
					errors++;
					$display("%0t: event_key%0d expected %0d actual %0d",
						$time, k, want.evt[k], got.evt[k]);
				end
			end
		endfunction

		function int pending();
			return results_due.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_idx;
	cfg_data_t cfg_wdata;

	kdpc_tick_if   tk ();
	kdpc_result_if res ();

	key_event_scoreboard sb;

	int tx_idle_pct;
	int rx_stall_pct;
	bit hold_off_req;
	int cycles = 0;
	bit key_level[KEY_SLOTS];

	key_debounce_press_classifier_core #(
		.NUM_KEYS(LANES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tk),
		.result   (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch the register port and both channels at the rising edge
	always @(posedge clk) begin
		key_result_t r;
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_idx, cfg_wdata);
			if (res.valid && res.ready) begin
				r.mask   = res.pressed_mask;
				r.evt[0] = res.event_key0;
				r.evt[1] = res.event_key1;
				r.evt[2] = res.event_key2;
				r.evt[3] = res.event_key3;
				r.evt[4] = res.event_key4;
				r.evt[5] = res.event_key5;
				sb.check_result(r);
			end
			if (tk.valid && tk.ready)
				sb.note_tick(tk.pin_levels);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Drive result ready: random stalls, or a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && hold_left == 0)
				hold_left = HOLD_OFF_LEN;
			@(negedge clk);
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// Offer one tick after a random gap and hold it until accepted
	task automatic send_tick(input key_mask_t pins);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			tk.valid      <= 1'b0;
			tk.pin_levels <= key_mask_t'($urandom);
			@(negedge clk);
		end
		tk.valid      <= 1'b1;
		tk.pin_levels <= pins;
		do
			@(posedge clk);
		while (!tk.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait for every expected transaction, then the pipe latency
	task automatic drain();
		tk.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg_port(input cfg_idx_t idx, input cfg_data_t data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// Program all timing registers; upper bits of the mask word carry noise
	task automatic program_timing(input key_mask_t act, input logic [7:0] stp,
		input logic [15:0] deb, input logic [15:0] lng);
		write_reg_port(REG_ACTIVE_LEVELS, {10'($urandom), act});
		write_reg_port(REG_TIME_STEP, {8'($urandom), stp});
		write_reg_port(REG_DEBOUNCE, deb);
		write_reg_port(REG_LONG_PRESS, lng);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Random key activity: held levels that toggle now and then, with bounce
	task automatic run_phase(input key_mask_t act, input logic [7:0] stp,
		input logic [15:0] deb, input logic [15:0] lng, input int n_ticks,
		input int run_len, input int bounce_pm, input int tx_pct, input int rx_pct,
		input bit with_hold_off);
		key_mask_t pins;
		program_timing(act, stp, deb, lng);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		if (with_hold_off) begin
			hold_off_req = 1'b1;
			@(negedge clk);
			hold_off_req = 1'b0;
		end
		for (int i = 0; i < n_ticks; i++) begin
			for (int k = 0; k < KEY_SLOTS; k++) begin
				if ($urandom_range(1, run_len) == 1)
					key_level[k] = ~key_level[k];
				pins[k] = key_level[k] ^ ($urandom_range(0, 999) < bounce_pm);
			end
			send_tick(pins);
		end
		drain();
	endtask

	initial begin
		key_mask_t    seq[$];
		logic [7:0]   stp;
		logic [15:0]  deb;
		sb           = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_ACTIVE_LEVELS;
		cfg_wdata    = '0;
		tk.valid     = 1'b0;
		tk.pin_levels = '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_off_req = 1'b0;
		for (int k = 0; k < KEY_SLOTS; k++)
			key_level[k] = 1'b0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: press to long, release, short press, bounce
		program_timing(6'h0F, 8'd10, 16'd20, 16'd60);
		seq = '{6'h00, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F,
			6'h00, 6'h00, 6'h00, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h00, 6'h00, 6'h00,
			6'h00, 6'h15, 6'h2A, 6'h15, 6'h2A};
		foreach (seq[i])
			send_tick(seq[i]);
		drain();

		// Timing settings, extremes among them, with rotating flow control
		run_phase(6'h2A, 8'd10, 16'd20, 16'd100, 60, 15, 60, 0, 0, 1'b1);
		run_phase(6'h3F, 8'd1, 16'd0, 16'd5, 60, 6, 80, 82, 0, 1'b0);
		run_phase(6'h00, 8'd255, 16'hFFFF, 16'hFFFF, 600, 1000, 0, 0, 82, 1'b0);
		run_phase(key_mask_t'($urandom), 8'd0, 16'd0, 16'd0, 60, 5, 50, 20, 20, 1'b0);
		run_phase(key_mask_t'($urandom), 8'd255, 16'd255, 16'd2550, 60, 20, 40, 0, 0,
			1'b0);
		run_phase(key_mask_t'($urandom), 8'd7, 16'd30, 16'd0, 60, 12, 60, 82, 0, 1'b0);
		run_phase(key_mask_t'($urandom), 8'd200, 16'd0, 16'hFFFF, 400, 500, 5, 0, 82,
			1'b0);
		for (int p = 0; p < 3; p++) begin
			stp = 8'($urandom_range(1, 255));
			deb = 16'($urandom_range(0, 4 * int'(stp)));
			run_phase(key_mask_t'($urandom), stp, deb,
				16'($urandom_range(int'(deb), 30 * int'(stp))), 60, 20, 60,
				(p == 1) ? 82 : 20, (p == 2) ? 82 : 20, 1'b0);
		end

		// Back to reset timing for a final stretch
		run_phase(ACTIVE_LEVELS_RST, TIME_STEP_RST, DEBOUNCE_RST, LONG_PRESS_RST, 60, 40,
			30, 0, 0, 1'b0);

		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
		end
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
